/* hdl/dimu_pkg.sv */
// Shared types and constants for the dual attitude frame parser.
package dimu_pkg;

  localparam int DIMU_MAX_FRAME = 32;

  localparam logic [7:0] SHORT_HDR0 = 8'h55;
  localparam logic [7:0] SHORT_HDR1 = 8'h53;
  localparam logic [7:0] LONG_HDR0  = 8'hAA;
  localparam logic [7:0] LONG_HDR1  = 8'h55;

  // short frame: 11 bytes, check byte at the last position
  localparam int SHORT_LEN = 11;
  localparam logic [3:0] SHORT_LAST = 4'(SHORT_LEN - 1);

  // raw * 18000 >> 15 gives centidegrees
  localparam logic signed [15:0] SHORT_SCALE = 16'sd18000;

  // long frame: header, two bytes, length, payload, check byte
  localparam int LONG_LEN_POS   = 4;
  localparam int LONG_PL_BASE   = 5;
  localparam int LONG_OVERHEAD  = 6;
  localparam int LONG_PL_SHORT  = 6;
  localparam int LONG_PL_FULL   = 18;
  localparam int LONG_FULL_OFS  = 12;

  typedef enum logic [1:0] {
    SEV_NONE     = 2'd0,
    SEV_HEADER   = 2'd1,
    SEV_VALID    = 2'd2,
    SEV_CSUM_ERR = 2'd3
  } short_ev_t;

  typedef enum logic [2:0] {
    LEV_NONE     = 3'd0,
    LEV_HEADER   = 3'd1,
    LEV_VALID    = 3'd2,
    LEV_CSUM_ERR = 3'd3,
    LEV_LEN_ERR  = 3'd4
  } long_ev_t;

  // attitude update offered by one parser for the current word
  typedef struct packed {
    logic               upd;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [16:0] yaw;
  } att_upd_t;

endpackage

/* hdl/dual_imu_frame_parser.sv */
// Top level: two serial attitude frame parsers fed from one byte stream.
//
// Input channel: in_valid/in_ready with in_rx_byte, one received serial
// byte per word. Output channel: out_valid/out_ready, one result word per
// input word, carrying the event code of each parser, the current roll,
// pitch and yaw in centidegrees and a flag that this byte changed them.
// The short parser takes 11-byte 55 53 frames and scales the raw angles
// by 18000/32768; the long parser takes AA 55 frames with a length byte
// and payloads up to 26 bytes, attitude only from payloads of 6 or 18
// bytes. If both finish on one byte the long frame's attitude is kept.
// The result is registered: out_valid rises in the cycle after accept.
// Throughput is one byte per cycle while results are taken; parser state
// and results update on accept; one shared 16x16 short-path multiplier.
// in_ready is high while the result register is empty or being taken, so
// a stalled receiver holds the result and back-pressures the input.
// Synchronous reset clears parser positions and sums, attitude and out_valid.
module dual_imu_frame_parser import dimu_pkg::*; #(
  parameter int MAX_FRAME = DIMU_MAX_FRAME
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_short_frame_event,
  output logic [2:0]         out_long_frame_event,
  output logic signed [15:0] out_roll_cdeg,
  output logic signed [15:0] out_pitch_cdeg,
  output logic signed [16:0] out_yaw_cdeg,
  output logic               out_attitude_changed
);

  logic      step;
  short_ev_t sev;
  long_ev_t  lev;
  att_upd_t  s_att, l_att;

  logic               out_valid_r;
  short_ev_t          sev_r;
  long_ev_t           lev_r;
  logic               chg_r;
  logic signed [15:0] roll_r, roll_nxt;
  logic signed [15:0] pitch_r, pitch_nxt;
  logic signed [16:0] yaw_r, yaw_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  dimu_short_parser u_short (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_rx_byte),
    .ev      (sev),
    .att     (s_att)
  );

  dimu_long_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_long (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_rx_byte),
    .ev      (lev),
    .att     (l_att)
  );

  // long frame checked first, so it wins over the short one
  always_comb begin
    roll_nxt  = roll_r;
    pitch_nxt = pitch_r;
    yaw_nxt   = yaw_r;
    if (l_att.upd) begin
      roll_nxt  = l_att.roll;
      pitch_nxt = l_att.pitch;
      yaw_nxt   = l_att.yaw;
    end else if (s_att.upd) begin
      roll_nxt  = s_att.roll;
      pitch_nxt = s_att.pitch;
      yaw_nxt   = s_att.yaw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      roll_r      <= '0;
      pitch_r     <= '0;
      yaw_r       <= '0;
    end else begin
      if (step) begin
        out_valid_r <= 1'b1;
        roll_r      <= roll_nxt;
        pitch_r     <= pitch_nxt;
        yaw_r       <= yaw_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      sev_r <= sev;
      lev_r <= lev;
      chg_r <= s_att.upd || l_att.upd;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_short_frame_event = sev_r;
  assign out_long_frame_event  = lev_r;
  assign out_roll_cdeg         = roll_r;
  assign out_pitch_cdeg        = pitch_r;
  assign out_yaw_cdeg          = yaw_r;
  assign out_attitude_changed  = chg_r;

  a_chg_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && chg_r |-> (sev_r == SEV_VALID || lev_r == LEV_VALID))
    else $error("attitude change without a valid frame");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted word gave no result");

  a_att_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && !(s_att.upd || l_att.upd) |=>
      roll_r == $past(roll_r) && pitch_r == $past(pitch_r) && yaw_r == $past(yaw_r))
    else $error("attitude moved without an update");

endmodule

/* hdl/dimu_short_parser.sv */
// Parser for 11-byte 55 53 frames with running sum and scaled attitude.
module dimu_short_parser import dimu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output short_ev_t  ev,
  output att_upd_t   att
);

  logic [3:0]         pos_r, pos_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [7:0]         lo_r, lo_nxt;
  logic signed [15:0] roll_r, roll_nxt;
  logic signed [15:0] pitch_r, pitch_nxt;
  logic signed [15:0] yaw_r, yaw_nxt;

  logic signed [15:0] raw;
  logic signed [31:0] prod;
  logic signed [15:0] scaled;

  // one shared multiplier: each angle is scaled when its high byte arrives
  assign raw    = $signed({rx_byte, lo_r});
  assign prod   = raw * SHORT_SCALE;
  assign scaled = prod[30:15];

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    roll_nxt  = roll_r;
    pitch_nxt = pitch_r;
    yaw_nxt   = yaw_r;
    ev        = SEV_NONE;
    att.upd   = 1'b0;
    att.roll  = roll_r;
    att.pitch = pitch_r;
    att.yaw   = {yaw_r[15], yaw_r};
    if (pos_r == 4'd0) begin
      if (rx_byte == SHORT_HDR0) begin
        sum_nxt = rx_byte;
        pos_nxt = 4'd1;
      end
    end else if (pos_r == 4'd1) begin
      if (rx_byte == SHORT_HDR1) begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = 4'd2;
        ev      = SEV_HEADER;
      end else if (rx_byte == SHORT_HDR0) begin
        sum_nxt = rx_byte;
      end else begin
        sum_nxt = '0;
        pos_nxt = 4'd0;
      end
    end else if (pos_r >= SHORT_LAST) begin
      pos_nxt = 4'd0;
      if (sum_r == rx_byte) begin
        ev      = SEV_VALID;
        att.upd = 1'b1;
      end else begin
        ev = SEV_CSUM_ERR;
      end
    end else begin
      sum_nxt = sum_r + rx_byte;
      pos_nxt = pos_r + 4'd1;
      case (pos_r)
        4'd3:    roll_nxt  = scaled;
        4'd5:    pitch_nxt = scaled;
        4'd7:    yaw_nxt   = scaled;
        default: lo_nxt    = rx_byte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      lo_r    <= lo_nxt;
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= SHORT_LAST)
    else $error("short parser position out of range");

  a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev == SEV_HEADER |=> pos_r == 4'd2)
    else $error("short header did not advance to data");

  a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    step && (ev == SEV_VALID || ev == SEV_CSUM_ERR) |=> pos_r == 4'd0)
    else $error("short frame end did not return to hunt");

endmodule

/* hdl/dimu_long_parser.sv */
// Parser for variable-length AA 55 frames with length check and running sum.
module dimu_long_parser import dimu_pkg::*; #(
  parameter int MAX_FRAME = DIMU_MAX_FRAME
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output long_ev_t   ev,
  output att_upd_t   att
);

  localparam int         PW      = $clog2(MAX_FRAME + 1);
  localparam logic [8:0] LEN_MAX = 9'(MAX_FRAME - LONG_OVERHEAD);
  localparam int         NPL     = 6;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] exp_r, exp_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic          wr_data;

  // kept bytes: payload 0..5 and payload 12..17
  logic [7:0] pl_r  [NPL];
  logic [7:0] ext_r [NPL];

  logic [PW:0] pos_inc;
  assign pos_inc = {1'b0, pos_r} + (PW+1)'(1);

  always_comb begin
    pos_nxt   = pos_r;
    exp_nxt   = exp_r;
    sum_nxt   = sum_r;
    wr_data   = 1'b0;
    ev        = LEV_NONE;
    att.upd   = 1'b0;
    att.roll  = $signed({pl_r[5], pl_r[4]});
    att.pitch = $signed({pl_r[3], pl_r[2]});
    att.yaw   = $signed({1'b0, pl_r[1], pl_r[0]});
    if (pos_r == PW'(0)) begin
      if (rx_byte == LONG_HDR0) pos_nxt = PW'(1);
    end else if (pos_r == PW'(1)) begin
      if (rx_byte == LONG_HDR1) begin
        pos_nxt = PW'(2);
        exp_nxt = '0;
        sum_nxt = '0;
        ev      = LEV_HEADER;
      end else if (rx_byte != LONG_HDR0) begin
        pos_nxt = PW'(0);
      end
    end else if (exp_r != '0 && pos_inc >= {1'b0, exp_r}) begin
      pos_nxt = '0;
      exp_nxt = '0;
      if (sum_r != rx_byte) begin
        ev = LEV_CSUM_ERR;
      end else begin
        ev = LEV_VALID;
        if (exp_r == PW'(LONG_PL_SHORT + LONG_OVERHEAD)) begin
          att.upd = 1'b1;
        end else if (exp_r == PW'(LONG_PL_FULL + LONG_OVERHEAD)) begin
          att.upd   = 1'b1;
          att.pitch = $signed({ext_r[1], ext_r[0]});
          att.roll  = $signed({ext_r[3], ext_r[2]});
          att.yaw   = $signed({1'b0, ext_r[5], ext_r[4]});
        end
      end
    end else begin
      wr_data = 1'b1;
      sum_nxt = sum_r + rx_byte;
      pos_nxt = pos_inc[PW-1:0];
      if (pos_r == PW'(LONG_LEN_POS)) begin
        if ({1'b0, rx_byte} > LEN_MAX) begin
          pos_nxt = '0;
          exp_nxt = '0;
          ev      = LEV_LEN_ERR;
        end else begin
          exp_nxt = PW'({1'b0, rx_byte} + 9'(LONG_OVERHEAD));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      exp_r <= '0;
      sum_r <= '0;
    end else if (step) begin
      pos_r <= pos_nxt;
      exp_r <= exp_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NPL; i++) begin
      if (step && wr_data && pos_r == PW'(LONG_PL_BASE + i))
        pl_r[i] <= rx_byte;
      if (step && wr_data && pos_r == PW'(LONG_PL_BASE + LONG_FULL_OFS + i))
        ext_r[i] <= rx_byte;
    end
  end

  a_exp_min: assert property (@(posedge clk) disable iff (!rst_n)
    exp_r == '0 || exp_r >= PW'(LONG_OVERHEAD))
    else $error("long frame expected length below overhead");

  a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev == LEV_HEADER |=> pos_r == PW'(2) && exp_r == '0)
    else $error("long header did not start a new frame");

  a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
    step && ev == LEV_LEN_ERR |=> pos_r == '0 && exp_r == '0)
    else $error("long length error did not drop the frame");

endmodule
